/* rtl/core/dart_pkg.sv */
// ----------------------------------------------------------------------------
// dart_pkg
// Shared types and constants for the divider and reloading timer.
// ----------------------------------------------------------------------------
package dart_pkg;

   localparam int DIVIDER_PERIOD_DEF = 256;

   localparam int PERIOD_W   = 13;
   localparam int COUNT_W    = 8;
   localparam int SPEED_W    = 2;
   localparam int NUM_SPEEDS = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // register indexes on the config port
   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SELECT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELOAD_VALUE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_SEL0  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_SEL1  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_SEL2  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_SEL3  = 3'd6;

   localparam logic [PERIOD_W-1:0] PERIOD_SEL0_RST = 13'd1024;
   localparam logic [PERIOD_W-1:0] PERIOD_SEL1_RST = 13'd16;
   localparam logic [PERIOD_W-1:0] PERIOD_SEL2_RST = 13'd64;
   localparam logic [PERIOD_W-1:0] PERIOD_SEL3_RST = 13'd256;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic                                   timer_enable;
      logic [SPEED_W-1:0]                     speed_select;
      logic [COUNT_W-1:0]                     reload_value;
      logic [NUM_SPEEDS-1:0][PERIOD_W-1:0]    period_sel;
   } cfg_type;

endpackage

/* rtl/core/dart_csr.sv */
// ----------------------------------------------------------------------------
// dart_csr
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module dart_csr
   import dart_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TIMER_ENABLE: cfg_in.timer_enable  = csr_data[0];
            CSR_SPEED_SELECT: cfg_in.speed_select  = csr_data[SPEED_W-1:0];
            CSR_RELOAD_VALUE: cfg_in.reload_value  = csr_data[COUNT_W-1:0];
            CSR_PERIOD_SEL0:  cfg_in.period_sel[0] = csr_data[PERIOD_W-1:0];
            CSR_PERIOD_SEL1:  cfg_in.period_sel[1] = csr_data[PERIOD_W-1:0];
            CSR_PERIOD_SEL2:  cfg_in.period_sel[2] = csr_data[PERIOD_W-1:0];
            CSR_PERIOD_SEL3:  cfg_in.period_sel[3] = csr_data[PERIOD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timer_enable  <= 1'b0;
         cfg_ff.speed_select  <= '0;
         cfg_ff.reload_value  <= '0;
         cfg_ff.period_sel[0] <= PERIOD_SEL0_RST;
         cfg_ff.period_sel[1] <= PERIOD_SEL1_RST;
         cfg_ff.period_sel[2] <= PERIOD_SEL2_RST;
         cfg_ff.period_sel[3] <= PERIOD_SEL3_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/dart_core.sv */
// ----------------------------------------------------------------------------
// dart_core
// Divider and timer counter state, updated once per processed beat.
// ----------------------------------------------------------------------------
module dart_core
   import dart_pkg::*;
#(
   parameter int DIVIDER_PERIOD = DIVIDER_PERIOD_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic               advance,
   input  cfg_type            cfg,
   output logic [COUNT_W-1:0] divider_next,
   output logic [COUNT_W-1:0] counter_next,
   output logic               irq_next
);

   localparam int DIV_W = (DIVIDER_PERIOD > 1) ? $clog2(DIVIDER_PERIOD) : 1;
   localparam logic [DIV_W:0] DIV_LIMIT = DIVIDER_PERIOD[DIV_W:0];

   logic [DIV_W-1:0]    div_pre_ff,  div_pre_in;
   logic [COUNT_W-1:0]  div_cnt_ff,  div_cnt_in;
   logic [PERIOD_W-1:0] tmr_pre_ff,  tmr_pre_in;
   logic [COUNT_W-1:0]  tmr_cnt_ff,  tmr_cnt_in;
   logic                irq;

   logic [DIV_W:0]      div_sum;
   logic [PERIOD_W:0]   tmr_sum;
   logic [PERIOD_W-1:0] period;

   assign div_sum = {1'b0, div_pre_ff} + {{DIV_W{1'b0}}, 1'b1};
   assign tmr_sum = {1'b0, tmr_pre_ff} + {{PERIOD_W{1'b0}}, 1'b1};
   assign period  = cfg.period_sel[cfg.speed_select];

   always_comb begin
      div_pre_in = div_pre_ff;
      div_cnt_in = div_cnt_ff;
      tmr_pre_in = tmr_pre_ff;
      tmr_cnt_in = tmr_cnt_ff;
      irq        = 1'b0;
      if (advance) begin
         if (div_sum >= DIV_LIMIT) begin
            div_pre_in = '0;
            div_cnt_in = div_cnt_ff + 1'b1;
         end else begin
            div_pre_in = div_sum[DIV_W-1:0];
         end
         if (cfg.timer_enable) begin
            // count at or past the period ticks the counter
            if (tmr_sum >= {1'b0, period}) begin
               tmr_pre_in = '0;
               if (tmr_cnt_ff == COUNT_MAX) begin
                  tmr_cnt_in = cfg.reload_value;
                  irq        = 1'b1;
               end else begin
                  tmr_cnt_in = tmr_cnt_ff + 1'b1;
               end
            end else begin
               tmr_pre_in = tmr_sum[PERIOD_W-1:0];
            end
         end
      end
   end

   assign divider_next = div_cnt_in;
   assign counter_next = tmr_cnt_in;
   assign irq_next     = irq;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_pre_ff <= '0;
         div_cnt_ff <= '0;
         tmr_pre_ff <= '0;
         tmr_cnt_ff <= '0;
      end else if (step_en) begin
         div_pre_ff <= div_pre_in;
         div_cnt_ff <= div_cnt_in;
         tmr_pre_ff <= tmr_pre_in;
         tmr_cnt_ff <= tmr_cnt_in;
      end
   end

endmodule

/* rtl/core/divider_and_reloading_timer.sv */
// ----------------------------------------------------------------------------
// divider_and_reloading_timer
// Free-running divider plus a prescaled counter that reloads on overflow.
//
//  channel  dir  handshake            payload
//  req_     in   req_tvalid/tready    tdata[0] advance
//  rsp_     out  rsp_tvalid/tready    tdata[7:0] divider, [15:8] counter, [16] irq
//  csr_     in   csr_valid/ready      csr_index, csr_data
//
// one beat per cycle sustained while the result side accepts; a beat waits in the
// input register, then the state update and the result register load happen together.
// reset is synchronous: counters clear, periods return to their defaults.
// a stalled result holds the input register; the request side stalls only when
// both registers are full.
// ----------------------------------------------------------------------------
module divider_and_reloading_timer
   import dart_pkg::*;
#(
   parameter int DIVIDER_PERIOD = DIVIDER_PERIOD_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] advance, [7:1] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [7:0] divider_value,
                                              // [15:8] counter_value,
                                              // [16] timer_interrupt, [23:17] zero
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type            cfg;
   logic               in_valid_ff;
   logic               in_adv_ff;
   logic               out_valid_ff;
   logic [COUNT_W-1:0] out_div_ff, out_cnt_ff;
   logic               out_irq_ff;
   logic [COUNT_W-1:0] divider_next, counter_next;
   logic               irq_next;
   logic               step;

   // input beat moves into the result register when that one is free or drains
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   dart_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dart_core #(
      .DIVIDER_PERIOD (DIVIDER_PERIOD)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step),
      .advance      (in_adv_ff),
      .cfg          (cfg),
      .divider_next (divider_next),
      .counter_next (counter_next),
      .irq_next     (irq_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_adv_ff <= req_tdata[0];
      end
      if (step) begin
         out_div_ff <= divider_next;
         out_cnt_ff <= counter_next;
         out_irq_ff <= irq_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_irq_ff, out_cnt_ff, out_div_ff};

endmodule
